// ===== sv/tlpq_pkg.sv =====
// Package for the three-level priority queue: codes, chain and status types.
// Used by every module of the block but tlpq_ram; no dependencies.
`timescale 1ns / 1ps

package tlpq_pkg;

    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int NUM_LEVELS      = 3;
    localparam int BYTE_W          = 8;
    localparam int LEVEL_W         = 2;
    localparam int STATUS_W        = 3;

    localparam logic [LEVEL_W-1:0] LVL_NONE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_FIRST = 2'd1;

    typedef enum logic
    {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_ENQUEUED = 3'd0,
        ST_DEQUEUED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADPRIO  = 3'd4
    } status_t;

    // Broadcast command seen by every cell in the cycle an item is accepted
    typedef struct packed
    {
        logic               accept;
        op_t                op;
        logic [LEVEL_W-1:0] prio;
    } cmd_t;

    // Handed from one cell to the next: open dequeue request and level number
    typedef struct packed
    {
        logic               deq_req;
        logic [LEVEL_W-1:0] level;
    } chain_t;

    // Per-cell outcome of the current item
    typedef struct packed
    {
        logic enq_full;
        logic deq_hit;
    } cell_stat_t;

endpackage

// ===== sv/tlpq_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on tlpq_pkg.
`timescale 1ns / 1ps

interface tlpq_req_if;
    import tlpq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [BYTE_W-1:0]  item_byte;
    logic [LEVEL_W-1:0] priority_req;

    modport source (output valid, operation, item_byte, priority_req, input ready);
    modport sink   (input valid, operation, item_byte, priority_req, output ready);
endinterface

interface tlpq_rsp_if;
    import tlpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [LEVEL_W-1:0]  served_level;

    modport source (output valid, status, out_byte, served_level, input ready);
    modport sink   (input valid, status, out_byte, served_level, output ready);
endinterface

// ===== sv/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tlpq_cell.sv =====
// One priority level: FIFO pointers, fill count and entry RAM.
// Depends on tlpq_pkg and tlpq_ram; cells are chained by the dequeue request.
`timescale 1ns / 1ps

module tlpq_cell #(
    parameter int DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlpq_pkg::cmd_t              cmd,
    input  logic [tlpq_pkg::BYTE_W-1:0] item_byte,
    input  tlpq_pkg::chain_t            chain_in,
    output tlpq_pkg::chain_t            chain_out,
    output tlpq_pkg::cell_stat_t        stat,
    output logic [tlpq_pkg::BYTE_W-1:0] rd_data
);
    import tlpq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic full;
    logic empty;
    logic enq_sel;
    logic do_enq;
    logic do_deq;

    // Decode this cell's share of the item
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign enq_sel = cmd.accept && (cmd.op == OP_ENQ) && (cmd.prio == chain_in.level);
    assign do_enq  = enq_sel && !full;
    assign do_deq  = chain_in.deq_req && !empty;

    // Pass an unserved dequeue on to the next lower level
    assign chain_out.deq_req = chain_in.deq_req && empty;
    assign chain_out.level   = chain_in.level + LEVEL_W'(1);

    assign stat.enq_full = enq_sel && full;
    assign stat.deq_hit  = do_deq;

    // Pointer and count update, wrapping at the level depth
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_enq)
        begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
        if (do_deq)
        begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage for this level
    tlpq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_enq),
        .wr_addr (tail_reg),
        .wr_data (item_byte),
        .rd_en   (do_deq),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

endmodule

// ===== sv/three_level_priority_queue.sv =====
// Three-level strict-priority FIFO queue of bytes: a chain of three level cells.
// An accepted request passes stage 1 (RAM read), then the output register, before response valid.
// Throughput: one item per cycle unless rsp stalls; the cell chain updates pointers at accept.
// Reset (rst_n, async, active low) empties all levels; entry RAM is not cleared.
// Depends on tlpq_pkg, tlpq_if, tlpq_cell and tlpq_ram.
`timescale 1ns / 1ps

module three_level_priority_queue #(
    parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    tlpq_req_if.sink   req,
    tlpq_rsp_if.source rsp
);
    import tlpq_pkg::*;

    cmd_t              cmd;
    chain_t            chain [NUM_LEVELS+1];
    cell_stat_t        stat  [NUM_LEVELS];
    logic [BYTE_W-1:0] rd_data [NUM_LEVELS];

    logic         accept;
    logic         enq_full_any;
    logic         deq_any;
    logic [LEVEL_W-1:0] deq_level;
    status_t      status_comb;
    logic [LEVEL_W-1:0] level_comb;

    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic [LEVEL_W-1:0] s1_level_reg;
    logic               s1_move;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [LEVEL_W-1:0] out_level_reg;

    // Handshake: stage 1 frees up when it moves into the output register
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    assign cmd.accept = accept;
    assign cmd.op     = op_t'(req.operation);
    assign cmd.prio   = req.priority_req;

    // Head of the chain: level 1 sees the dequeue request first
    assign chain[0].deq_req = accept && (req.operation == OP_DEQ);
    assign chain[0].level   = LVL_FIRST;

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_cell
        tlpq_cell #(
            .DEPTH (LEVEL_DEPTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .item_byte (req.item_byte),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g]),
            .rd_data   (rd_data[g])
        );
    end

    // Collect cell outcomes
    always_comb
    begin
        enq_full_any = 1'b0;
        deq_any      = 1'b0;
        deq_level    = LVL_NONE;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            enq_full_any = enq_full_any | stat[i].enq_full;
            if (stat[i].deq_hit)
            begin
                deq_any   = 1'b1;
                deq_level = chain[i].level;
            end
        end
    end

    // Result code for the accepted item
    always_comb
    begin
        status_comb = ST_ENQUEUED;
        level_comb  = req.priority_req;
        if (req.operation == OP_DEQ)
        begin
            status_comb = deq_any ? ST_DEQUEUED : ST_EMPTY;
            level_comb  = deq_any ? deq_level : LVL_NONE;
        end
        else if (req.priority_req == LVL_NONE)
        begin
            status_comb = ST_BADPRIO;
            level_comb  = LVL_NONE;
        end
        else if (enq_full_any)
        begin
            status_comb = ST_FULL;
        end
    end

    // Stage 1: waits for the RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_comb;
            s1_level_reg  <= level_comb;
        end
    end

    // Pick the read data of the level that was served
    always_comb
    begin
        out_byte_next = '0;
        if (s1_status_reg == ST_DEQUEUED)
        begin
            case (s1_level_reg)
                2'd1:    out_byte_next = rd_data[0];
                2'd2:    out_byte_next = rd_data[1];
                2'd3:    out_byte_next = rd_data[2];
                default: out_byte_next = '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_status_reg <= s1_status_reg;
            out_byte_reg   <= out_byte_next;
            out_level_reg  <= s1_level_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_byte     = out_byte_reg;
    assign rsp.served_level = out_level_reg;

endmodule

// ===== sv/tlpq_checker.sv =====
// Port-level checks for the three-level priority queue, bound to the top level.
// Depends on tlpq_pkg and three_level_priority_queue.
`timescale 1ns / 1ps

module tlpq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [tlpq_pkg::STATUS_W-1:0] rsp_status,
    input logic [tlpq_pkg::BYTE_W-1:0]   rsp_out_byte,
    input logic [tlpq_pkg::LEVEL_W-1:0]  rsp_served_level
);
    import tlpq_pkg::*;

    // A stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_out_byte) && $stable(rsp_served_level))
        else $error("response changed while stalled");

    // Only a dequeue returns a byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_DEQUEUED) |-> rsp_out_byte == '0)
        else $error("nonzero byte on a non-dequeue response");

    // Empty and bad priority touch no level
    a_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_EMPTY) || (rsp_status == ST_BADPRIO))
            |-> rsp_served_level == LVL_NONE)
        else $error("level reported for empty or bad-priority response");

    // Enqueue, full and dequeue always name a level
    a_has_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ST_ENQUEUED) || (rsp_status == ST_DEQUEUED)
            || (rsp_status == ST_FULL)) |-> rsp_served_level != LVL_NONE)
        else $error("missing level on a queue response");

endmodule

bind three_level_priority_queue tlpq_checker u_tlpq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_out_byte     (rsp.out_byte),
    .rsp_served_level (rsp.served_level)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for three_level_priority_queue: a directed table, then random phases.
// Depends on tlpq_pkg, tlpq_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import tlpq_pkg::*;

    localparam int LEVEL_DEPTH = LEVEL_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 15;
    localparam int PHASE_ITEMS = 110;
    localparam int N_DIRECTED  = 21;

    typedef struct packed
    {
        status_t            status;
        logic [BYTE_W-1:0]  out_byte;
        logic [LEVEL_W-1:0] served_level;
    } rsp_item_t;

    // One directed row; rsp is used only when fixed is set
    typedef struct packed
    {
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [LEVEL_W-1:0] prio;
        logic               fixed;
        rsp_item_t          rsp;
    } dir_row_t;

    typedef enum int
    {
        PH_MIX,
        PH_FILL,
        PH_DRAIN
    } phase_kind_t;

    logic clk;
    logic rst_n;

    tlpq_req_if req_if ();
    tlpq_rsp_if rsp_if ();

    three_level_priority_queue #(
        .LEVEL_DEPTH(LEVEL_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    // Shadow of the level FIFOs
    logic [BYTE_W-1:0] lvl_store [NUM_LEVELS][LEVEL_DEPTH];
    int                lvl_head  [NUM_LEVELS];
    int                lvl_tail  [NUM_LEVELS];
    int                lvl_count [NUM_LEVELS];

    rsp_item_t awaited_rsp[$];
    int        fail_count    = 0;
    int        cycle_count   = 0;
    int        send_gap_pct  = 0;
    int        rsp_stall_pct = 0;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_EMPTY,    8'h00, LVL_NONE}},
        '{OP_ENQ, 8'hFF, 2'd0, 1'b1, '{ST_BADPRIO,  8'h00, LVL_NONE}},
        '{OP_ENQ, 8'h00, 2'd0, 1'b1, '{ST_BADPRIO,  8'h00, LVL_NONE}},
        '{OP_DEQ, 8'hFF, 2'd3, 1'b1, '{ST_EMPTY,    8'h00, LVL_NONE}},
        '{OP_ENQ, 8'h00, 2'd3, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd3}},
        '{OP_ENQ, 8'hFF, 2'd2, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd2}},
        '{OP_ENQ, 8'h80, 2'd1, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd1}},
        '{OP_ENQ, 8'h7F, 2'd1, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd1}},
        '{OP_ENQ, 8'h01, 2'd3, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd3}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_DEQUEUED, 8'h80, 2'd1}},
        '{OP_ENQ, 8'h55, 2'd2, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd2}},
        '{OP_DEQ, 8'hFF, 2'd2, 1'b1, '{ST_DEQUEUED, 8'h7F, 2'd1}},
        '{OP_DEQ, 8'h00, 2'd1, 1'b1, '{ST_DEQUEUED, 8'hFF, 2'd2}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_DEQUEUED, 8'h55, 2'd2}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_DEQUEUED, 8'h00, 2'd3}},
        '{OP_ENQ, 8'hAA, 2'd1, 1'b1, '{ST_ENQUEUED, 8'h00, 2'd1}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_DEQUEUED, 8'hAA, 2'd1}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_DEQUEUED, 8'h01, 2'd3}},
        '{OP_DEQ, 8'h00, 2'd0, 1'b1, '{ST_EMPTY,    8'h00, LVL_NONE}},
        '{OP_ENQ, 8'h3C, 2'd2, 1'b0, '{ST_ENQUEUED, 8'h00, LVL_NONE}},
        '{OP_DEQ, 8'hAA, 2'd1, 1'b0, '{ST_ENQUEUED, 8'h00, LVL_NONE}}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Strict-priority queue behavior: updates the shadow FIFOs, returns the response
    function automatic rsp_item_t predict_queue(op_t op, logic [BYTE_W-1:0] data,
                                                logic [LEVEL_W-1:0] prio);
        rsp_item_t r;
        int        lv;
        r = '{ST_EMPTY, 8'h00, LVL_NONE};
        if (op == OP_ENQ)
        begin
            if (prio == LVL_NONE)
            begin
                r.status = ST_BADPRIO;
            end
            else
            begin
                lv = int'(prio) - 1;
                r.served_level = prio;
                if (lvl_count[lv] >= LEVEL_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    lvl_store[lv][lvl_tail[lv]] = data;
                    lvl_tail[lv] = (lvl_tail[lv] + 1) % LEVEL_DEPTH;
                    lvl_count[lv]++;
                    r.status = ST_ENQUEUED;
                end
            end
        end
        else
        begin
            for (lv = 0; lv < NUM_LEVELS; lv++)
            begin
                if (lvl_count[lv] != 0)
                begin
                    r.status       = ST_DEQUEUED;
                    r.out_byte     = lvl_store[lv][lvl_head[lv]];
                    r.served_level = LEVEL_W'(lv + 1);
                    lvl_head[lv]   = (lvl_head[lv] + 1) % LEVEL_DEPTH;
                    lvl_count[lv]--;
                    break;
                end
            end
        end
        return r;
    endfunction

    // Present one request item, optionally after a short gap, and wait for accept
    task automatic send_req(op_t op, logic [BYTE_W-1:0] data, logic [LEVEL_W-1:0] prio,
                            logic fixed, rsp_item_t fixed_rsp);
        rsp_item_t predicted;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.item_byte    <= data;
        req_if.priority_req <= prio;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        predicted = predict_queue(op, data, prio);
        awaited_rsp.push_back(fixed ? fixed_rsp : predicted);
    endtask

    // Hold the request side until every outstanding response is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Compare one accepted response with the oldest expectation
    task automatic check_rsp();
        rsp_item_t want;
        if (awaited_rsp.size() == 0)
        begin
            $error("unexpected response: status %0d out_byte %0h served_level %0d",
                   rsp_if.status, rsp_if.out_byte, rsp_if.served_level);
            fail_count++;
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (rsp_if.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                fail_count++;
            end
            if (rsp_if.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_if.out_byte);
                fail_count++;
            end
            if (rsp_if.served_level !== want.served_level)
            begin
                $error("served_level: expected %0d, got %0d",
                       want.served_level, rsp_if.served_level);
                fail_count++;
            end
        end
    endtask

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            check_rsp();
        end
    end

    // Receiver: drops ready in random bursts, as rsp_stall_pct sets
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL three_level_priority_queue");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        phase_kind_t        kind;
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [LEVEL_W-1:0] prio;
        logic [LEVEL_W-1:0] fill_lv;
        int                 deq_pct;
        int                 pick;

        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = 1'b0;
        req_if.item_byte    = '0;
        req_if.priority_req = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            lvl_head[i]  = 0;
            lvl_tail[i]  = 0;
            lvl_count[i] = 0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: empty, bad priority, extremes, priority order
        send_gap_pct  = 25;
        rsp_stall_pct = 25;
        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].op, dir_rows[i].data, dir_rows[i].prio,
                     dir_rows[i].fixed, dir_rows[i].rsp);
        end

        // Random phases: first one fills a level past full, second drains it all
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                kind = PH_FILL;
            else if (ph == 1)
                kind = PH_DRAIN;
            else
                kind = phase_kind_t'($urandom_range(0, 2));
            fill_lv = LEVEL_W'($urandom_range(1, 3));
            case (kind)
                PH_FILL:  deq_pct = 10;
                PH_DRAIN: deq_pct = 85;
                default:  deq_pct = 45;
            endcase

            // No idling at the tail of the run
            if (ph >= NUM_PHASES - 2)
            begin
                send_gap_pct  = 0;
                rsp_stall_pct = 0;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                send_gap_pct  = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
                pick = $urandom_range(0, 2);
                rsp_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                data = BYTE_W'($urandom_range(0, 255));
                prio = LEVEL_W'($urandom_range(0, 3));
                if ($urandom_range(99) < deq_pct)
                begin
                    op = OP_DEQ;
                end
                else
                begin
                    op   = OP_ENQ;
                    pick = $urandom_range(99);
                    if (pick < 5)
                        prio = LVL_NONE;
                    else if (kind == PH_FILL && pick < 85)
                        prio = fill_lv;
                    else
                        prio = LEVEL_W'($urandom_range(1, 3));
                end
                send_req(op, data, prio, 1'b0, '{ST_EMPTY, 8'h00, LVL_NONE});
            end

            // Sender holds off until the block has answered everything
            if (ph == 3 || ph == 8)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS three_level_priority_queue");
        end
        else
        begin
            $display("FAIL three_level_priority_queue");
        end
        $finish;
    end

endmodule
